// ----- hw/rtl/sha256_pkg.sv -----
// SHA-256 digest unit shared types, constants and a rotate function
package sha256_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES = 8192;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = 2;

  // command from front to back
  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_FINISH,
    CMD_ERROR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [7:0]       data;
    logic [LEN_W-1:0] length;
  } cmd_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- hw/rtl/sha256_front.sv -----
// Front end: length tracking, overflow detection, command generation
module sha256_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  input  logic                message_end,
  input  logic                push,
  output logic                full,
  output sha256_pkg::cmd_t    cmd,
  output logic                cmd_valid,
  input  logic                cmd_ready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BYTE,
    S_END
  } state_t;

  state_t                         state;
  logic [sha256_pkg::LEN_W-1:0]   message_bytes;
  logic                           too_long;
  logic [7:0]                     data;
  logic                           has_end;

  assign full = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd_valid = 1'b0;
    case (state)
      S_BYTE: begin
        cmd.op = sha256_pkg::CMD_BYTE;
        cmd.data = data;
        cmd_valid = 1'b1;
      end
      S_END: begin
        cmd.op = too_long ? sha256_pkg::CMD_ERROR : sha256_pkg::CMD_FINISH;
        cmd.length = message_bytes;
        cmd_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      message_bytes <= '0;
      too_long <= 1'b0;
      has_end <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (push) begin
            data <= data_byte;
            has_end <= message_end;
            if (byte_present && !too_long) begin
              if (message_bytes >= sha256_pkg::LEN_W'(sha256_pkg::MAX_MESSAGE_BYTES)) begin
                too_long <= 1'b1;
                if (message_end) state <= S_END;
              end else begin
                message_bytes <= message_bytes + 1'b1;
                state <= S_BYTE;
              end
            end else if (message_end) begin
              state <= S_END;
            end
          end
        end
        S_BYTE: begin
          if (cmd_ready) state <= has_end ? S_END : S_IDLE;
        end
        S_END: begin
          if (cmd_ready) begin
            state <= S_IDLE;
            message_bytes <= '0;
            too_long <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sha256_cmd_queue.sv -----
// Short command queue between front and back
module sha256_cmd_queue (
  input  logic             clk,
  input  logic             rst,
  input  sha256_pkg::cmd_t in_cmd,
  input  logic             in_valid,
  output logic             in_ready,
  output sha256_pkg::cmd_t out_cmd,
  output logic             out_valid,
  input  logic             out_ready
);

  sha256_pkg::cmd_t                entries [sha256_pkg::QUEUE_DEPTH];
  logic [sha256_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [sha256_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [sha256_pkg::QUEUE_AW:0]   count;
  logic                            do_wr;
  logic                            do_rd;

  assign in_ready = (count != (sha256_pkg::QUEUE_AW+1)'(sha256_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd = entries[rd_ptr];
  assign do_wr = in_valid && in_ready;
  assign do_rd = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= in_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (!do_wr && do_rd) count <= count - 1'b1;
    end
  end

endmodule

// ----- hw/rtl/sha256_back.sv -----
// Back end: byte packing, padding, 64-round compression and digest output
module sha256_back (
  input  logic             clk,
  input  logic             rst,
  input  sha256_pkg::cmd_t cmd,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  output logic [31:0]      digest_word,
  output logic             word_last,
  output logic             error,
  output logic             empty,
  input  logic             pop
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_UPDATE,
    S_OUT,
    S_ERR
  } state_t;

  state_t       state;
  logic [31:0]  chain_hash [8];
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [5:0]   block_fill;
  logic [5:0]   round;
  logic [63:0]  length_bits;
  logic         padding;
  logic         pad_first;
  logic         pad_extra;
  logic [2:0]   out_idx;
  logic [31:0]  wt;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  ws0;
  logic [31:0]  ws1;
  logic [7:0]   pad_byte;
  logic [3:0]   widx;

  assign cmd_ready = (state == S_IDLE);
  assign empty = !((state == S_OUT) || (state == S_ERR));
  assign digest_word = (state == S_ERR) ? 32'h0 : chain_hash[out_idx];
  assign word_last = (state == S_ERR) || (out_idx == 3'd7);
  assign error = (state == S_ERR);
  assign widx = block_fill[5:2];

  always_comb begin
    ws0 = sha256_pkg::rotr(w[1], 7) ^ sha256_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    ws1 = sha256_pkg::rotr(w[14], 17) ^ sha256_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wt = w[0];
    t1 = v[7] + (sha256_pkg::rotr(v[4], 6) ^ sha256_pkg::rotr(v[4], 11)
         ^ sha256_pkg::rotr(v[4], 25)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + sha256_pkg::ROUND_K[round] + wt;
    t2 = (sha256_pkg::rotr(v[0], 2) ^ sha256_pkg::rotr(v[0], 13)
         ^ sha256_pkg::rotr(v[0], 22)) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    if (pad_first) pad_byte = sha256_pkg::PAD_BYTE;
    else if (block_fill >= 6'd56 && !pad_extra)
      pad_byte = length_bits[8*(7-block_fill[2:0]) +: 8];
    else pad_byte = 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      block_fill <= '0;
      padding <= 1'b0;
      pad_first <= 1'b0;
      pad_extra <= 1'b0;
      out_idx <= '0;
      round <= '0;
      for (int i = 0; i < 8; i++) chain_hash[i] <= sha256_pkg::INIT_HASH[i];
      for (int i = 0; i < 8; i++) v[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              sha256_pkg::CMD_BYTE: begin
                w[widx] <= {w[widx][23:0], cmd.data};
                block_fill <= block_fill + 1'b1;
                if (block_fill == 6'd63) begin
                  state <= S_ROUND;
                  round <= '0;
                  for (int i = 0; i < 8; i++) v[i] <= chain_hash[i];
                end
              end
              sha256_pkg::CMD_FINISH: begin
                length_bits <= {45'h0, cmd.length, 3'b000};
                padding <= 1'b1;
                pad_first <= 1'b1;
                pad_extra <= 1'b0;
                state <= S_PAD;
              end
              sha256_pkg::CMD_ERROR: state <= S_ERR;
              default: ;
            endcase
          end
        end
        S_PAD: begin
          w[widx] <= {w[widx][23:0], pad_byte};
          pad_first <= 1'b0;
          // no room for the length after the 0x80 byte: one more block follows
          if (pad_first && block_fill >= 6'd56) pad_extra <= 1'b1;
          block_fill <= block_fill + 1'b1;
          if (block_fill == 6'd63) begin
            state <= S_ROUND;
            round <= '0;
            for (int i = 0; i < 8; i++) v[i] <= chain_hash[i];
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w[0] + ws0 + w[9] + ws1;
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          round <= round + 1'b1;
          if (round == 6'd63) state <= S_UPDATE;
        end
        S_UPDATE: begin
          for (int i = 0; i < 8; i++) chain_hash[i] <= chain_hash[i] + v[i];
          if (!padding) state <= S_IDLE;
          else if (pad_extra) begin
            state <= S_PAD;
            pad_extra <= 1'b0;
          end else begin
            state <= S_OUT;
            out_idx <= '0;
          end
        end
        S_OUT: begin
          if (pop) begin
            out_idx <= out_idx + 1'b1;
            if (out_idx == 3'd7) begin
              state <= S_IDLE;
              padding <= 1'b0;
              for (int i = 0; i < 8; i++) chain_hash[i] <= sha256_pkg::INIT_HASH[i];
              for (int i = 0; i < 8; i++) v[i] <= '0;
            end
          end
        end
        S_ERR: begin
          if (pop) begin
            state <= S_IDLE;
            block_fill <= '0;
            for (int i = 0; i < 8; i++) chain_hash[i] <= sha256_pkg::INIT_HASH[i];
            for (int i = 0; i < 8; i++) v[i] <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sha256_message_digest_unit.sv -----
// SHA-256 message digest unit top level
// Each full block of bytes is compressed in the back end. At message end the
// block is padded byte by byte and compressed, then eight digest words are
// offered, one a pop.
// Throughput is set by the single shared round unit, one round per cycle.
// Synchronous active-high reset loads the initial hash and empties the queue.
module sha256_message_digest_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        message_end,
  input  logic        push,
  output logic        full,
  output logic [31:0] digest_word,
  output logic        word_last,
  output logic        error,
  output logic        empty,
  input  logic        pop
);

  sha256_pkg::cmd_t front_cmd;
  sha256_pkg::cmd_t back_cmd;
  logic             front_valid;
  logic             front_ready;
  logic             back_valid;
  logic             back_ready;

  sha256_front u_front (
    .clk(clk), .rst(rst),
    .data_byte(data_byte), .byte_present(byte_present), .message_end(message_end),
    .push(push), .full(full),
    .cmd(front_cmd), .cmd_valid(front_valid), .cmd_ready(front_ready)
  );

  sha256_cmd_queue u_queue (
    .clk(clk), .rst(rst),
    .in_cmd(front_cmd), .in_valid(front_valid), .in_ready(front_ready),
    .out_cmd(back_cmd), .out_valid(back_valid), .out_ready(back_ready)
  );

  sha256_back u_back (
    .clk(clk), .rst(rst),
    .cmd(back_cmd), .cmd_valid(back_valid), .cmd_ready(back_ready),
    .digest_word(digest_word), .word_last(word_last), .error(error),
    .empty(empty), .pop(pop)
  );

endmodule
